// ----- hw/rtl/rhc_pkg.sv -----
// rhc_pkg: constants, stage record and helper functions for the rgb/hsv converter
// depends on nothing; used by rgb_hsv_converter_core
package rhc_pkg;

  localparam int unsigned ChanBits  = 8;
  localparam int unsigned NumStages = 19;
  localparam int unsigned DivSteps  = 16;
  localparam int unsigned DivFirst  = 3;
  localparam int unsigned InBits    = 72;
  localparam int unsigned OutBits   = 72;

  localparam logic [16:0] SatOne   = 17'd65536;
  localparam logic [19:0] HueTurn6 = 20'd393216;

  typedef enum logic {
    ACT_RGB2HSV = 1'b0,
    ACT_HSV2RGB = 1'b1
  } action_e;

  typedef struct packed {
    logic             act;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [15:0]      hue;
    logic [16:0]      sat;
    logic [7:0]       val;
    logic [7:0]       mx;
    logic [7:0]       d;
    logic [10:0]      num;
    logic             gray;
    logic             black;
    logic [16:0]      scl;
    logic [2:0][16:0] f;
    logic [10:0]      hd;
    logic [10:0]      hrem;
    logic [15:0]      hlow;
    logic [15:0]      hq;
    logic [7:0]       sd;
    logic [7:0]       srem;
    logic [15:0]      slow;
    logic [16:0]      sq;
    logic [2:0][33:0] sf;
    logic [2:0][40:0] vk;
    logic [2:0][7:0]  ch;
  } stage_t;

  // triangle weight of one channel, n in units of a sixth turn
  function automatic logic [16:0] chan_weight(input logic [2:0] n, input logic [15:0] hue);
    logic [19:0]        k;
    logic signed [20:0] fo;
    logic signed [20:0] fm;
    begin
      k = {n, 17'd0} - {1'b0, n, 16'd0} + 20'(hue) * 20'd6;
      if (k >= HueTurn6) begin
        k = k - HueTurn6;
      end
      fo = 21'sd262144 - $signed({1'b0, k});
      fm = $signed({1'b0, k});
      if (fo < fm) begin
        fm = fo;
      end
      if (fm > 21'sd65536) begin
        fm = 21'sd65536;
      end
      if (fm < 21'sd0) begin
        fm = 21'sd0;
      end
      chan_weight = fm[16:0];
    end
  endfunction

endpackage

// ----- hw/rtl/rgb_hsv_converter_core.sv -----
// rgb_hsv_converter_core: pixel converter between rgb and hsv, 19-stage pipeline
// depends on rhc_pkg
//
// One item per clock while the output is not stalled; the depth is set by the two
// restoring dividers (hue and saturation) that resolve one quotient bit per stage.
// All stages advance together whenever the output stage is empty or being taken,
// so a stall freezes the pipe.
module rgb_hsv_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // red, green, blue, hue, saturation, value, zero fill
  input  logic [rhc_pkg::InBits-1:0]  s_axis_tdata_i,
  // action
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // red, green, blue, hue, saturation, value, zero fill
  output logic [rhc_pkg::OutBits-1:0] m_axis_tdata_o
);

  rhc_pkg::stage_t st_q [rhc_pkg::NumStages];
  rhc_pkg::stage_t st_d [rhc_pkg::NumStages];
  logic [rhc_pkg::NumStages-1:0] vld_q;
  logic adv;

  assign adv             = !vld_q[rhc_pkg::NumStages-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_comb begin
    logic [7:0]  r, g, b, mx, mn, dd;
    logic [11:0] ht;
    logic [8:0]  stv;
    logic        ge;
    logic [32:0] keep;
    st_d = st_q;
    // capture
    st_d[0]       = st_q[0];
    st_d[0].act   = s_axis_tuser_i;
    st_d[0].red   = s_axis_tdata_i[7:0];
    st_d[0].green = s_axis_tdata_i[15:8];
    st_d[0].blue  = s_axis_tdata_i[23:16];
    st_d[0].hue   = s_axis_tdata_i[39:24];
    st_d[0].sat   = s_axis_tdata_i[56:40];
    st_d[0].val   = s_axis_tdata_i[64:57];
    // extremes, hue numerator, channel weights
    st_d[1] = st_q[0];
    r = st_q[0].red;
    g = st_q[0].green;
    b = st_q[0].blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dd = mx - mn;
    st_d[1].mx    = mx;
    st_d[1].d     = dd;
    st_d[1].gray  = (dd == 8'd0);
    st_d[1].black = (mx == 8'd0);
    if (mx == r) begin
      if (g >= b) st_d[1].num = 11'(g - b);
      else        st_d[1].num = 11'(12'(dd) * 12'd6 - 12'(b) + 12'(g));
    end else if (mx == g) begin
      st_d[1].num = 11'(12'(dd) * 12'd2 + 12'(b) - 12'(r));
    end else begin
      st_d[1].num = 11'(12'(dd) * 12'd4 + 12'(r) - 12'(g));
    end
    st_d[1].scl  = (st_q[0].sat > rhc_pkg::SatOne) ? rhc_pkg::SatOne : st_q[0].sat;
    st_d[1].f[0] = rhc_pkg::chan_weight(3'd5, st_q[0].hue);
    st_d[1].f[1] = rhc_pkg::chan_weight(3'd3, st_q[0].hue);
    st_d[1].f[2] = rhc_pkg::chan_weight(3'd1, st_q[0].hue);
    // divider setup and saturation products
    st_d[2]      = st_q[1];
    st_d[2].hd   = 11'(st_q[1].d) * 11'd6;
    st_d[2].hrem = st_q[1].num;
    st_d[2].hlow = 16'(st_q[1].d) * 16'd3;
    st_d[2].hq   = '0;
    st_d[2].sd   = st_q[1].mx;
    st_d[2].slow = 16'(st_q[1].mx >> 1);
    ge = (st_q[1].d >= st_q[1].mx);
    st_d[2].srem = ge ? (st_q[1].d - st_q[1].mx) : st_q[1].d;
    st_d[2].sq   = {16'd0, ge};
    for (int c = 0; c < 3; c++) begin
      st_d[2].sf[c] = 34'(st_q[1].scl) * 34'(st_q[1].f[c]);
    end
    // one quotient bit of each division per stage
    for (int k = 0; k < rhc_pkg::DivSteps; k++) begin
      st_d[rhc_pkg::DivFirst+k] = st_q[rhc_pkg::DivFirst+k-1];
      ht = {st_q[rhc_pkg::DivFirst+k-1].hrem, st_q[rhc_pkg::DivFirst+k-1].hlow[15-k]};
      ge = (ht >= {1'b0, st_q[rhc_pkg::DivFirst+k-1].hd});
      st_d[rhc_pkg::DivFirst+k].hrem = ge ? 11'(ht - {1'b0, st_q[rhc_pkg::DivFirst+k-1].hd})
                                          : ht[10:0];
      st_d[rhc_pkg::DivFirst+k].hq = {st_q[rhc_pkg::DivFirst+k-1].hq[14:0], ge};
      stv = {st_q[rhc_pkg::DivFirst+k-1].srem, st_q[rhc_pkg::DivFirst+k-1].slow[15-k]};
      ge = (stv >= {1'b0, st_q[rhc_pkg::DivFirst+k-1].sd});
      st_d[rhc_pkg::DivFirst+k].srem = ge ? 8'(stv - {1'b0, st_q[rhc_pkg::DivFirst+k-1].sd})
                                          : stv[7:0];
      st_d[rhc_pkg::DivFirst+k].sq = {st_q[rhc_pkg::DivFirst+k-1].sq[15:0], ge};
    end
    // channel scaling and rounding ride along the divider stages
    for (int c = 0; c < 3; c++) begin
      keep = 33'h1_0000_0000 - 33'(st_q[2].sf[c]);
      st_d[3].vk[c] = 41'(st_q[2].val) * 41'(keep);
      st_d[4].ch[c] = 8'((st_q[3].vk[c] + 41'h0_8000_0000) >> 32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[rhc_pkg::NumStages-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < rhc_pkg::NumStages; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  rhc_pkg::stage_t ls;
  logic [7:0]  o_red, o_green, o_blue, o_val;
  logic [15:0] o_hue;
  logic [16:0] o_sat;

  assign ls = st_q[rhc_pkg::NumStages-1];

  always_comb begin
    if (rhc_pkg::action_e'(ls.act) == rhc_pkg::ACT_HSV2RGB) begin
      o_red   = ls.ch[0];
      o_green = ls.ch[1];
      o_blue  = ls.ch[2];
      o_hue   = ls.hue;
      o_sat   = ls.sat;
      o_val   = ls.val;
    end else begin
      o_red   = ls.red;
      o_green = ls.green;
      o_blue  = ls.blue;
      o_hue   = ls.gray ? 16'd0 : ls.hq;
      o_sat   = ls.black ? 17'd0 : ls.sq;
      o_val   = ls.mx;
    end
  end

  assign m_axis_tvalid_o = vld_q[rhc_pkg::NumStages-1];
  assign m_axis_tdata_o  = {7'd0, o_val, o_sat, o_hue, o_blue, o_green, o_red};

`ifndef NO_ASSERTIONS
  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !ls.act && ls.red == ls.green && ls.green == ls.blue
    |-> o_hue == 16'd0)
    else $error("gray pixel gave nonzero hue");
  a_value_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !ls.act
    |-> o_val >= ls.red && o_val >= ls.green && o_val >= ls.blue)
    else $error("value below a channel");
  a_dark_rgb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ls.act && ls.val == 8'd0
    |-> o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0)
    else $error("zero value gave nonzero channel");
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !ls.act |-> o_sat <= rhc_pkg::SatOne)
    else $error("saturation above one");
`endif

endmodule
